>>> src/ptd_pkg.sv
// ptd_pkg: shared item types, command and status codes for the periodic task dispatcher
// used by ptd_mod, periodic_task_dispatcher and the bench; depends on nothing
package ptd_pkg;

    localparam int MAX_RESULTS = 8;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_CREATE  = 3'd1;
    localparam logic [2:0] CMD_DELETE  = 3'd2;
    localparam logic [2:0] CMD_RESUME  = 3'd3;
    localparam logic [2:0] CMD_SUSPEND = 3'd4;

    localparam logic [3:0] ST_CREATED      = 4'd0;
    localparam logic [3:0] ST_TAKEN        = 4'd1;
    localparam logic [3:0] ST_DELETED      = 4'd2;
    localparam logic [3:0] ST_BAD_INDEX    = 4'd3;
    localparam logic [3:0] ST_RESUMED      = 4'd4;
    localparam logic [3:0] ST_RESUME_FAIL  = 4'd5;
    localparam logic [3:0] ST_SUSPENDED    = 4'd6;
    localparam logic [3:0] ST_SUSPEND_FAIL = 4'd7;
    localparam logic [3:0] ST_DISPATCH     = 4'd8;
    localparam logic [3:0] ST_NONE_DUE     = 4'd9;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  slot;
        logic [15:0] period;
    } cmd_item_t;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] due_slot;
        logic       dispatched;
        logic       last;
    } res_item_t;

    typedef struct packed {
        logic done;
        logic zero;
    } mod_rsp_t;

endpackage

>>> src/ptd_ram.sv
// ptd_ram: generic single write port, single read port ram with registered read
// depends on nothing
module ptd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ptd_mod.sv
// ptd_mod: bit-serial restoring remainder unit, one quotient bit per cycle
// reports whether a 16-bit dividend is a multiple of a nonzero divisor; uses ptd_pkg
module ptd_mod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [15:0]     dividend,
    input  logic [15:0]     divisor,
    output ptd_pkg::mod_rsp_t rsp
);

    logic [15:0] rem_reg;
    logic [15:0] dvd_reg;
    logic [15:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, dvd_reg[15]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd16;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 16'd0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(shifted - {1'b0, div_reg}) : shifted[15:0];
            dvd_reg <= {dvd_reg[14:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == 16'd0);

endmodule

>>> src/periodic_task_dispatcher.sv
// periodic_task_dispatcher: task slot table with create, delete, resume, suspend and tick
// uses ptd_pkg, ptd_ram (period table) and ptd_mod (serial remainder)
//
// usage:
//   cmd channel (cmd_valid, cmd_stall, cmd_item) carries one command item; the block
//   takes one item at a time and holds cmd_stall high while it works on it
//   res channel (res_valid, res_stall, res_item) returns one or more result items;
//   the final result of a command carries last
//   for create, delete, resume and suspend the S_END state gives the one result and
//   returns to idle, where the next command can be taken
//   tick: slots are scanned in index order through S_RD and S_CHK; each present,
//   running slot with a nonzero period also passes through the serial remainder
//   unit in S_DIV, and each due slot through S_DUE; the scan stops after the last slot
//   or after MAX_RESULTS due slots, and S_END gives the final result and returns to idle;
//   the one-bit-per-cycle remainder loop takes most of the tick time
//   unknown commands are accepted in idle and give no result
//   reset clears all present and running marks and the tick counter; the period
//   table is only used for slots that create has written, so it needs no clearing
//   a stalled receiver holds the output register; the scan waits while a result
//   is pending and the output register is still occupied
module periodic_task_dispatcher #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  ptd_pkg::cmd_item_t  cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output ptd_pkg::res_item_t  res_item
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CHK  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DUE  = 6'b010000,
        S_END  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [TASK_SLOTS-1:0]  present_reg, present_next;
    logic [TASK_SLOTS-1:0]  running_reg, running_next;
    logic [15:0]            tick_reg, tick_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   have_pend_reg, have_pend_next;
    logic                   is_tick_reg, is_tick_next;
    logic                   res_valid_reg, res_valid_next;
    ptd_pkg::res_item_t     pend_reg, pend_next;
    ptd_pkg::res_item_t     res_item_reg, res_item_next;

    logic                   ram_we;
    logic [15:0]            ram_rdata;
    logic                   mod_start;
    ptd_pkg::mod_rsp_t      mod_rsp;
    logic                   out_free;
    logic                   in_range;
    logic [SW-1:0]          sidx;
    logic                   advance;

    assign sidx     = cmd_item.slot[SW-1:0];
    assign in_range = {1'b0, cmd_item.slot} < 9'(TASK_SLOTS);
    assign out_free = !res_valid_reg || !res_stall;

    ptd_ram #(
        .WIDTH (16),
        .DEPTH (TASK_SLOTS)
    ) u_period_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sidx),
        .wdata (cmd_item.period),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    ptd_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (tick_reg),
        .divisor  (ram_rdata),
        .rsp      (mod_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        running_next   = running_reg;
        tick_next      = tick_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        have_pend_next = have_pend_reg;
        is_tick_next   = is_tick_reg;
        res_valid_next = res_valid_reg;
        pend_next      = pend_reg;
        res_item_next  = res_item_reg;
        ram_we         = 1'b0;
        mod_start      = 1'b0;
        advance        = 1'b0;
        cmd_stall      = (state_reg != S_IDLE);

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pend_next.due_slot   = 3'd0;
                    pend_next.dispatched = 1'b0;
                    pend_next.last       = 1'b1;
                    case (cmd_item.command)
                        ptd_pkg::CMD_TICK:
                        begin
                            idx_next       = '0;
                            cnt_next       = 4'd0;
                            have_pend_next = 1'b0;
                            is_tick_next   = 1'b1;
                            state_next     = S_RD;
                        end
                        ptd_pkg::CMD_CREATE, ptd_pkg::CMD_DELETE,
                        ptd_pkg::CMD_RESUME, ptd_pkg::CMD_SUSPEND:
                        begin
                            is_tick_next   = 1'b0;
                            have_pend_next = 1'b1;
                            state_next     = S_END;
                            if (!in_range)
                            begin
                                pend_next.status = ptd_pkg::ST_BAD_INDEX;
                            end
                            else if (cmd_item.command == ptd_pkg::CMD_CREATE)
                            begin
                                if (present_reg[sidx])
                                begin
                                    pend_next.status = ptd_pkg::ST_TAKEN;
                                end
                                else
                                begin
                                    ram_we             = 1'b1;
                                    present_next[sidx] = 1'b1;
                                    running_next[sidx] = 1'b1;
                                    pend_next.status   = ptd_pkg::ST_CREATED;
                                end
                            end
                            else if (cmd_item.command == ptd_pkg::CMD_DELETE)
                            begin
                                present_next[sidx] = 1'b0;
                                pend_next.status   = ptd_pkg::ST_DELETED;
                            end
                            else if (cmd_item.command == ptd_pkg::CMD_RESUME)
                            begin
                                if (present_reg[sidx])
                                begin
                                    running_next[sidx] = 1'b1;
                                    pend_next.status   = ptd_pkg::ST_RESUMED;
                                end
                                else
                                begin
                                    pend_next.status = ptd_pkg::ST_RESUME_FAIL;
                                end
                            end
                            else
                            begin
                                if (present_reg[sidx])
                                begin
                                    running_next[sidx] = 1'b0;
                                    pend_next.status   = ptd_pkg::ST_SUSPENDED;
                                end
                                else
                                begin
                                    pend_next.status = ptd_pkg::ST_SUSPEND_FAIL;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (present_reg[idx_reg] && running_reg[idx_reg] && ram_rdata != 16'd0)
                begin
                    mod_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_DIV:
            begin
                if (mod_rsp.done)
                begin
                    if (mod_rsp.zero)
                    begin
                        state_next = S_DUE;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end
            S_DUE:
            begin
                if (!have_pend_reg || out_free)
                begin
                    if (have_pend_reg)
                    begin
                        res_item_next      = pend_reg;
                        res_item_next.last = 1'b0;
                        res_valid_next     = 1'b1;
                    end
                    pend_next.status     = ptd_pkg::ST_DISPATCH;
                    pend_next.due_slot   = 3'(idx_reg);
                    pend_next.dispatched = 1'b1;
                    pend_next.last       = 1'b0;
                    have_pend_next       = 1'b1;
                    cnt_next             = cnt_reg + 4'd1;
                    advance              = 1'b1;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (have_pend_reg)
                    begin
                        res_item_next      = pend_reg;
                        res_item_next.last = 1'b1;
                    end
                    else
                    begin
                        res_item_next.status     = ptd_pkg::ST_NONE_DUE;
                        res_item_next.due_slot   = 3'd0;
                        res_item_next.dispatched = 1'b0;
                        res_item_next.last       = 1'b1;
                    end
                    if (is_tick_reg)
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (idx_reg == SW'(TASK_SLOTS - 1) || cnt_next == 4'(ptd_pkg::MAX_RESULTS))
            begin
                state_next = S_END;
            end
            else
            begin
                idx_next   = idx_reg + SW'(1);
                state_next = S_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            present_reg   <= '0;
            running_reg   <= '0;
            tick_reg      <= 16'd0;
            idx_reg       <= '0;
            cnt_reg       <= 4'd0;
            have_pend_reg <= 1'b0;
            is_tick_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            running_reg   <= running_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            have_pend_reg <= have_pend_next;
            is_tick_reg   <= is_tick_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

>>> bench/ptd_result_monitor.sv
// ptd_result_monitor: watches both channels of the periodic task dispatcher, keeps its own
// copy of the slot table and tick counter, predicts each result and compares it
// depends on ptd_pkg for the item types and the command and status codes
module ptd_result_monitor #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  ptd_pkg::cmd_item_t  cmd_item,
    input  logic                res_valid,
    input  logic                res_stall,
    input  ptd_pkg::res_item_t  res_item,
    output int                  fail_count,
    output int                  pending,
    output int                  result_count,
    output int                  dispatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0]           period_tbl [TASK_SLOTS];
    bit [TASK_SLOTS-1:0]   present_mask;
    bit [TASK_SLOTS-1:0]   running_mask;
    logic [15:0]           tick_cnt;
    ptd_pkg::res_item_t    awaited_results [$];
    int                    errors;
    int                    results;
    int                    dispatches;

    function automatic void apply_command(input ptd_pkg::cmd_item_t it);
        ptd_pkg::res_item_t r;
        int due;
        int idx;
        r = '0;
        due = 0;
        idx = int'(it.slot);
        if (it.command == ptd_pkg::CMD_TICK) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (present_mask[i] && running_mask[i] && period_tbl[i] != 16'd0
                    && tick_cnt % period_tbl[i] == 16'd0
                    && due < ptd_pkg::MAX_RESULTS) begin
                    r.status     = ptd_pkg::ST_DISPATCH;
                    r.due_slot   = 3'(i);
                    r.dispatched = 1'b1;
                    r.last       = 1'b0;
                    awaited_results.push_back(r);
                    due++;
                end
            end
            if (due == 0) begin
                r.status = ptd_pkg::ST_NONE_DUE;
                r.last   = 1'b1;
                awaited_results.push_back(r);
            end
            else
            begin
                awaited_results[awaited_results.size()-1].last = 1'b1;
            end
            tick_cnt = tick_cnt + 16'd1;
            return;
        end
        if (it.command > ptd_pkg::CMD_SUSPEND)
            return;
        r.last = 1'b1;
        if (idx >= TASK_SLOTS)
            r.status = ptd_pkg::ST_BAD_INDEX;
        else
        begin
            case (it.command)
                ptd_pkg::CMD_CREATE:
                begin
                    if (present_mask[idx])
                        r.status = ptd_pkg::ST_TAKEN;
                    else
                    begin
                        period_tbl[idx]   = it.period;
                        present_mask[idx] = 1'b1;
                        running_mask[idx] = 1'b1;
                        r.status          = ptd_pkg::ST_CREATED;
                    end
                end
                ptd_pkg::CMD_DELETE:
                begin
                    present_mask[idx] = 1'b0;
                    r.status          = ptd_pkg::ST_DELETED;
                end
                ptd_pkg::CMD_RESUME:
                begin
                    if (present_mask[idx])
                    begin
                        running_mask[idx] = 1'b1;
                        r.status          = ptd_pkg::ST_RESUMED;
                    end
                    else
                        r.status = ptd_pkg::ST_RESUME_FAIL;
                end
                default:
                begin
                    if (present_mask[idx])
                    begin
                        running_mask[idx] = 1'b0;
                        r.status          = ptd_pkg::ST_SUSPENDED;
                    end
                    else
                        r.status = ptd_pkg::ST_SUSPEND_FAIL;
                end
            endcase
        end
        awaited_results.push_back(r);
    endfunction

    task automatic check_result(input ptd_pkg::res_item_t got);
        ptd_pkg::res_item_t want;
        results++;
        if (got.dispatched === 1'b1)
            dispatches++;
        if (awaited_results.size() == 0)
        begin
            $error("unexpected result: status %0d due_slot %0d dispatched %0b last %0b",
                   got.status, got.due_slot, got.dispatched, got.last);
            errors++;
            return;
        end
        want = awaited_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.due_slot !== want.due_slot)
        begin
            $error("due_slot: expected %0d, got %0d", want.due_slot, got.due_slot);
            errors++;
        end
        if (got.dispatched !== want.dispatched)
        begin
            $error("dispatched: expected %0b, got %0b", want.dispatched, got.dispatched);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
                period_tbl[i] = 16'd0;
            present_mask = '0;
            running_mask = '0;
            tick_cnt     = 16'd0;
            awaited_results.delete();
            errors       = 0;
            results      = 0;
            dispatches   = 0;
        end
        else
        begin
            // results first: a result never belongs to an item accepted at the same edge
            if (res_valid && !res_stall)
                check_result(res_item);
            if (cmd_valid && !cmd_stall)
                apply_command(cmd_item);
        end
        fail_count     <= errors;
        pending        <= awaited_results.size();
        result_count   <= results;
        dispatch_count <= dispatches;
    end

endmodule

>>> bench/testbench.sv
// testbench: drives directed and random command items into the periodic
// task dispatcher under several idle and stall mixes and reports the verdict
// depends on ptd_pkg, periodic_task_dispatcher and ptd_result_monitor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_SLOTS   = 8;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 80;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    ptd_pkg::cmd_item_t  cmd_item  = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    ptd_pkg::res_item_t  res_item;

    int fail_count;
    int pending;
    int result_count;
    int dispatch_count;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int hold_cnt     = 0;
    int idle_cycles  = 0;
    int sent_count   = 0;
    int tick_sent    = 0;

    periodic_task_dispatcher #(.TASK_SLOTS(TASK_SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    ptd_result_monitor #(.TASK_SLOTS(TASK_SLOTS)) result_mon (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .cmd_item       (cmd_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .fail_count     (fail_count),
        .pending        (pending),
        .result_count   (result_count),
        .dispatch_count (dispatch_count)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, plus one long hold while the sender keeps offering items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            res_stall <= 1'b1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_cnt  = HOLD_CYCLES - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** periodic_task_dispatcher: FAILED **");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] command, input logic [7:0] slot,
                             input logic [15:0] period);
        ptd_pkg::cmd_item_t it;
        it.command = command;
        it.slot    = slot;
        it.period  = period;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent_count++;
        if (command == ptd_pkg::CMD_TICK)
            tick_sent++;
    endtask

    function automatic logic [15:0] pick_period();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(6, 1));
        if (r < 75)
            return 16'd0;
        return 16'($urandom);
    endfunction

    task automatic send_random_item(output bit counted);
        int r;
        logic [7:0] good_slot;
        r         = $urandom_range(99);
        good_slot = 8'($urandom_range(TASK_SLOTS - 1));
        counted   = 1'b1;
        if (r < 35)
            send_item(ptd_pkg::CMD_TICK, 8'($urandom), 16'($urandom));
        else if (r < 55)
            send_item(ptd_pkg::CMD_CREATE, good_slot, pick_period());
        else if (r < 68)
            send_item(ptd_pkg::CMD_DELETE, good_slot, 16'($urandom));
        else if (r < 80)
            send_item(ptd_pkg::CMD_RESUME, good_slot, 16'($urandom));
        else if (r < 92)
            send_item(ptd_pkg::CMD_SUSPEND, good_slot, 16'($urandom));
        else if (r < 96)
            send_item(3'($urandom_range(ptd_pkg::CMD_SUSPEND, ptd_pkg::CMD_CREATE)),
                      8'($urandom_range(255, TASK_SLOTS)), 16'($urandom));
        else
        begin
            send_item(3'($urandom_range(7, ptd_pkg::CMD_SUSPEND + 1)), 8'($urandom),
                      16'($urandom));
            counted = 1'b0;
        end
    endtask

    initial
    begin
        int tx_mix [4];
        int rx_mix [4];
        int counted_items;
        bit counted;
        tx_mix = '{0, 47, 0, 11};
        rx_mix = '{0, 0, 47, 11};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases
        send_item(ptd_pkg::CMD_TICK,    8'd0,   16'd0);
        send_item(ptd_pkg::CMD_CREATE,  8'd0,   16'd1);
        send_item(ptd_pkg::CMD_CREATE,  8'd0,   16'd5);
        send_item(ptd_pkg::CMD_CREATE,  8'd8,   16'd1);
        send_item(ptd_pkg::CMD_CREATE,  8'd255, 16'hffff);
        send_item(ptd_pkg::CMD_DELETE,  8'd200, 16'd0);
        send_item(ptd_pkg::CMD_RESUME,  8'd9,   16'd0);
        send_item(ptd_pkg::CMD_SUSPEND, 8'd128, 16'd0);
        send_item(ptd_pkg::CMD_RESUME,  8'd3,   16'd0);
        send_item(ptd_pkg::CMD_SUSPEND, 8'd3,   16'd0);
        send_item(ptd_pkg::CMD_CREATE,  8'd1,   16'd2);
        send_item(ptd_pkg::CMD_CREATE,  8'd2,   16'hffff);
        send_item(ptd_pkg::CMD_CREATE,  8'd3,   16'd0);
        send_item(ptd_pkg::CMD_CREATE,  8'd7,   16'd1);
        send_item(ptd_pkg::CMD_TICK,    8'd0,   16'd0);
        send_item(ptd_pkg::CMD_SUSPEND, 8'd7,   16'd0);
        send_item(ptd_pkg::CMD_TICK,    8'd0,   16'd0);
        send_item(ptd_pkg::CMD_DELETE,  8'd0,   16'd0);
        send_item(ptd_pkg::CMD_DELETE,  8'd0,   16'd0);
        send_item(ptd_pkg::CMD_RESUME,  8'd7,   16'd0);
        send_item(3'd5,                 8'd1,   16'd1);
        send_item(3'd6,                 8'd2,   16'd2);
        send_item(3'd7,                 8'd255, 16'hffff);
        send_item(ptd_pkg::CMD_TICK,    8'd255, 16'hffff);
        send_item(ptd_pkg::CMD_CREATE,  8'd0,   16'd1);

        // every task suspended, then a few resumed, then ticks
        for (int s = 0; s < TASK_SLOTS; s++)
            send_item(ptd_pkg::CMD_SUSPEND, 8'(s), 16'($urandom));
        send_item(ptd_pkg::CMD_RESUME, 8'd1, 16'd0);
        send_item(ptd_pkg::CMD_RESUME, 8'd2, 16'd0);
        send_item(ptd_pkg::CMD_RESUME, 8'd3, 16'd0);
        repeat (8)
            send_item(ptd_pkg::CMD_TICK, 8'($urandom), 16'($urandom));

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct = tx_mix[ph];
            rx_stall_pct <= rx_mix[ph];
            if (ph == 0)
                hold_req <= 1'b1;
            counted_items = 0;
            while (counted_items < PHASE_ITEMS)
            begin
                send_random_item(counted);
                if (counted)
                    counted_items++;
            end
        end

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered: %0d command items (%0d ticks), %0d results checked",
                 sent_count, tick_sent, result_count);
        $display("covered: %0d dispatches, four idle/stall mixes and one long output hold",
                 dispatch_count);
        if (fail_count == 0 && pending == 0)
            $display("** periodic_task_dispatcher: PASSED **");
        else
            $display("** periodic_task_dispatcher: FAILED **");
        $finish;
    end

endmodule

>>> files.f
src/ptd_pkg.sv
src/ptd_ram.sv
src/ptd_mod.sv
src/periodic_task_dispatcher.sv
bench/ptd_result_monitor.sv
bench/testbench.sv
